### sv/dtdb_pkg.sv
// ----------------------------------------------------------------------------
// Detailed timing builder package
// Shared types and constants for the detailed timing descriptor builder.
// ----------------------------------------------------------------------------
`default_nettype none

package dtdb_pkg;

	// Configuration register indexes
	localparam logic [3:0] REG_IMAGE_WIDTH  = 4'd0;
	localparam logic [3:0] REG_IMAGE_HEIGHT = 4'd1;

	// Reset values of the image size registers (mm)
	localparam logic [11:0] IMAGE_WIDTH_RST  = 12'd520;
	localparam logic [11:0] IMAGE_HEIGHT_RST = 12'd290;

	// Descriptor constants
	localparam logic [4:0] DESC_LAST_IDX = 5'd17;
	localparam logic [3:0] V_FRONT       = 4'd3;
	localparam logic [3:0] V_SYNC        = 4'd5;
	localparam logic [7:0] DTD_FLAGS     = 8'h1E;

	// One display mode
	typedef struct packed {
		logic [15:0] h_active;
		logic [15:0] v_active;
		logic [9:0]  refresh_hz;
	} mode_in_t;

	// One descriptor byte or reject
	typedef struct packed {
		logic [7:0] desc_byte;
		logic [4:0] byte_index;
		logic       mode_ok;
		logic       last_byte;
	} desc_out_t;

	// Derived geometry of a mode
	typedef struct packed {
		logic [11:0] h;
		logic [11:0] v;
		logic [7:0]  hb;
		logic [7:0]  vb;
		logic [7:0]  hf;
		logic [7:0]  hs;
	} geom_t;

	// Finished timing handed to the serialiser
	typedef struct packed {
		logic        ok;
		logic [15:0] clk10k;
		geom_t       geom;
	} timing_t;

endpackage

`default_nettype wire

### sv/dtdb_calc.sv
// ----------------------------------------------------------------------------
// Detailed timing calculation pipeline
// Six register stages: blanking, porches, two products, rounding and the
// reciprocal divide to 10 kHz units. Stalls from the serialiser back up.
// ----------------------------------------------------------------------------
`default_nettype none

module dtdb_calc (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  dtdb_pkg::mode_in_t in_mode,
	output logic               out_valid,
	input  wire                out_ready,
	output dtdb_pkg::timing_t  out_tim
);
	import dtdb_pkg::*;

	// Reciprocal constants: x/5 for x<1024, x/25 for x<1024, x/3 for x<256,
	// x/625 for x<2^26
	localparam logic [7:0]  DIV5_MUL    = 8'd205;
	localparam logic [10:0] DIV25_MUL   = 11'd1311;
	localparam logic [7:0]  DIV3_MUL    = 8'd171;
	localparam logic [26:0] DIV625_MUL  = 27'd109951163;
	localparam logic [35:0] CLK_LO_LIM  = 36'd5000;
	localparam logic [35:0] CLK_HI_LIM  = 36'd655355000;
	localparam logic [29:0] CLK_ROUND   = 30'd5000;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	// Stage ready chain: a stage moves when empty or when its successor moves
	assign rdy6     = !vld_s6 || out_ready;
	assign rdy5     = !vld_s5 || rdy6;
	assign rdy4     = !vld_s4 || rdy5;
	assign rdy3     = !vld_s3 || rdy4;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
			if (rdy6) vld_s6 <= vld_s5;
		end
	end

	// ---- stage 1: range check, horizontal / vertical blank, sync ----
	logic [11:0] h_in, v_in;
	logic [17:0] h20_prod, v20_prod;
	logic [20:0] h100_prod;
	logic [7:0]  h20, v20, h20_p7, hbr, hb_c, vb_c;
	logic [5:0]  h100, hs_m, hs_p7;
	logic [7:0]  hs_c;
	logic        bad_c;

	always_comb begin
		h_in      = in_mode.h_active[11:0];
		v_in      = in_mode.v_active[11:0];
		bad_c     = (in_mode.h_active == 16'd0) || (in_mode.v_active == 16'd0) ||
		            (in_mode.refresh_hz == 10'd0) ||
		            (in_mode.h_active > 16'd4095) || (in_mode.v_active > 16'd4095);
		// h/20 = (h/4)/5
		h20_prod  = 18'(h_in[11:2]) * 18'(DIV5_MUL);
		v20_prod  = 18'(v_in[11:2]) * 18'(DIV5_MUL);
		h20       = h20_prod[17:10];
		v20       = v20_prod[17:10];
		h20_p7    = h20 + 8'd7;
		hbr       = {h20_p7[7:3], 3'b000};
		hb_c      = (hbr > 8'd160) ? hbr : 8'd160;
		vb_c      = (v20 > 8'd30) ? v20 : 8'd30;
		// h/100 = (h/4)/25
		h100_prod = 21'(h_in[11:2]) * 21'(DIV25_MUL);
		h100      = h100_prod[20:15];
		hs_m      = (h100 > 6'd32) ? h100 : 6'd32;
		hs_p7     = hs_m + 6'd7;
		hs_c      = {2'b00, hs_p7[5:3], 3'b000};
	end

	logic        bad_s1;
	logic [11:0] h_s1, v_s1;
	logic [9:0]  r_s1;
	logic [7:0]  hb_s1, vb_s1, hs_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			bad_s1 <= bad_c;
			h_s1   <= h_in;
			v_s1   <= v_in;
			r_s1   <= in_mode.refresh_hz;
			hb_s1  <= hb_c;
			vb_s1  <= vb_c;
			hs_s1  <= hs_c;
		end
	end

	// ---- stage 2: front porch, blank overflow fallback, totals ----
	logic [15:0] hb3_prod;
	logic [6:0]  hb3, hf_m, hf_p7, hf_r;
	logic [8:0]  porch_sum;
	logic        porch_ovf;
	geom_t       geom_c2;
	logic [12:0] hsum_c, vsum_c;

	always_comb begin
		hb3_prod   = 16'(hb_s1) * 16'(DIV3_MUL);
		hb3        = hb3_prod[15:9];
		hf_m       = (hb3 > 7'd48) ? hb3 : 7'd48;
		hf_p7      = hf_m + 7'd7;
		hf_r       = {hf_p7[6:3], 3'b000};
		porch_sum  = 9'(hf_r) + 9'(hs_s1);
		porch_ovf  = porch_sum >= 9'(hb_s1);
		geom_c2.h  = h_s1;
		geom_c2.v  = v_s1;
		geom_c2.hb = hb_s1;
		geom_c2.vb = vb_s1;
		geom_c2.hf = porch_ovf ? 8'd48 : 8'(hf_r);
		geom_c2.hs = porch_ovf ? 8'd32 : hs_s1;
		hsum_c     = 13'(h_s1) + 13'(hb_s1);
		vsum_c     = 13'(v_s1) + 13'(vb_s1);
	end

	logic        bad_s2;
	logic [9:0]  r_s2;
	geom_t       geom_s2;
	logic [12:0] hsum_s2, vsum_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			bad_s2  <= bad_s1;
			r_s2    <= r_s1;
			geom_s2 <= geom_c2;
			hsum_s2 <= hsum_c;
			vsum_s2 <= vsum_c;
		end
	end

	// ---- stage 3: pixels per frame ----
	logic        bad_s3;
	logic [9:0]  r_s3;
	geom_t       geom_s3;
	logic [25:0] p1_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			bad_s3  <= bad_s2;
			r_s3    <= r_s2;
			geom_s3 <= geom_s2;
			p1_s3   <= 26'(hsum_s2) * 26'(vsum_s2);
		end
	end

	// ---- stage 4: pixels per second ----
	logic        bad_s4;
	geom_t       geom_s4;
	logic [35:0] p2_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			bad_s4  <= bad_s3;
			geom_s4 <= geom_s3;
			p2_s4   <= 36'(p1_s3) * 36'(r_s3);
		end
	end

	// ---- stage 5: clock range check and rounding ----
	// Rounded clock is 0 below 5000 Hz and above 65535 from 655355000 Hz
	logic [29:0] rnd_c;
	logic        ok_c5;

	always_comb begin
		rnd_c = p2_s4[29:0] + CLK_ROUND;
		ok_c5 = !bad_s4 && (p2_s4 >= CLK_LO_LIM) && (p2_s4 < CLK_HI_LIM);
	end

	logic        ok_s5;
	geom_t       geom_s5;
	logic [25:0] x_s5;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			ok_s5   <= ok_c5;
			geom_s5 <= geom_s4;
			x_s5    <= rnd_c[29:4];
		end
	end

	// ---- stage 6: divide by 625 through the reciprocal ----
	logic [52:0] q_prod;

	assign q_prod = 53'(x_s5) * 53'(DIV625_MUL);

	logic        ok_s6;
	geom_t       geom_s6;
	logic [15:0] clk_s6;

	always_ff @(posedge clk) begin
		if (rdy6) begin
			ok_s6   <= ok_s5;
			geom_s6 <= geom_s5;
			clk_s6  <= q_prod[51:36];
		end
	end

	// Present finished timing
	assign out_valid      = vld_s6;
	assign out_tim.ok     = ok_s6;
	assign out_tim.clk10k = clk_s6;
	assign out_tim.geom   = geom_s6;

endmodule

`default_nettype wire

### sv/dtdb_ser.sv
// ----------------------------------------------------------------------------
// Descriptor byte serialiser
// Holds one finished timing and emits its 18 descriptor bytes, or a single
// reject, one per cycle. Takes the next timing on the cycle of the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dtdb_ser (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  dtdb_pkg::timing_t   in_tim,
	input  wire  [11:0]         image_w,
	input  wire  [11:0]         image_h,
	output logic                res_valid,
	output dtdb_pkg::desc_out_t res
);
	import dtdb_pkg::*;

	logic      act_q;
	logic [4:0] cnt_q;
	timing_t   tim_q;
	logic      last_c;
	logic [7:0] byte_c;

	assign last_c   = !tim_q.ok || (cnt_q == DESC_LAST_IDX);
	assign in_ready = !act_q || last_c;

	// Track the byte position of the descriptor in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= 5'd0;
		end else if (in_valid && in_ready) begin
			act_q <= 1'b1;
			cnt_q <= 5'd0;
		end else if (act_q) begin
			if (last_c) begin
				act_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 5'd1;
			end
		end
	end

	// Hold the timing while its bytes go out
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tim_q <= in_tim;
		end
	end

	// Select the descriptor byte at the current position
	always_comb begin
		case (cnt_q)
			5'd0:    byte_c = tim_q.clk10k[7:0];
			5'd1:    byte_c = tim_q.clk10k[15:8];
			5'd2:    byte_c = tim_q.geom.h[7:0];
			5'd3:    byte_c = tim_q.geom.hb;
			// blank stays below 256, so its high nibble is zero
			5'd4:    byte_c = {tim_q.geom.h[11:8], 4'h0};
			5'd5:    byte_c = tim_q.geom.v[7:0];
			5'd6:    byte_c = tim_q.geom.vb;
			5'd7:    byte_c = {tim_q.geom.v[11:8], 4'h0};
			5'd8:    byte_c = tim_q.geom.hf;
			5'd9:    byte_c = tim_q.geom.hs;
			5'd10:   byte_c = {V_FRONT, V_SYNC};
			// porch and sync high bits are all zero at these sizes
			5'd11:   byte_c = 8'h00;
			5'd12:   byte_c = image_w[7:0];
			5'd13:   byte_c = image_h[7:0];
			5'd14:   byte_c = {image_w[11:8], image_h[11:8]};
			5'd17:   byte_c = DTD_FLAGS;
			default: byte_c = 8'h00;
		endcase
	end

	// Drive the result transfer
	assign res_valid      = act_q;
	assign res.desc_byte  = tim_q.ok ? byte_c : 8'h00;
	assign res.byte_index = tim_q.ok ? cnt_q : 5'd0;
	assign res.mode_ok    = tim_q.ok;
	assign res.last_byte  = last_c;

endmodule

`default_nettype wire

### sv/display_detailed_timing_builder_top.sv
// ----------------------------------------------------------------------------
// Display detailed timing builder
// Turns a display mode into the 18-byte detailed timing descriptor.
//
//   Channel   Signals                                Transfer when
//   --------  -------------------------------------  --------------------------
//   mode in   start, busy, mode                      start && !busy
//   result    result_valid, result                   result_valid (no stall)
//   config    cfg_valid, cfg_ready, cfg_index,       cfg_valid && cfg_ready
//             cfg_data
//
// A mode enters a six-stage calculation pipeline, then the serialiser, which
// drives the result port. The byte-wide result port sets the rate: 18 bytes
// per encodable mode, a single reject per rejected mode. Up to six modes
// wait in the pipeline; busy rises when it is full behind the serialiser.
// Reset empties the pipeline and loads image size 520 x 290 mm. The result
// side cannot stall; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module display_detailed_timing_builder_top (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  dtdb_pkg::mode_in_t  mode,
	output logic                result_valid,
	output dtdb_pkg::desc_out_t result,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [3:0]          cfg_index,
	input  wire  [15:0]         cfg_data
);
	import dtdb_pkg::*;

	logic [11:0] image_w_q, image_h_q;
	logic        calc_in_ready;
	logic        tim_valid, tim_ready;
	timing_t     tim;

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_w_q <= IMAGE_WIDTH_RST;
			image_h_q <= IMAGE_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_w_q <= cfg_data[11:0];
				REG_IMAGE_HEIGHT: image_h_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	assign busy = !calc_in_ready;

	dtdb_calc u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.in_ready  (calc_in_ready),
		.in_mode   (mode),
		.out_valid (tim_valid),
		.out_ready (tim_ready),
		.out_tim   (tim)
	);

	dtdb_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tim_valid),
		.in_ready  (tim_ready),
		.in_tim    (tim),
		.image_w   (image_w_q),
		.image_h   (image_h_q),
		.res_valid (result_valid),
		.res       (result)
	);

endmodule

`default_nettype wire
